// ===== rtl/core/lk2_pkg.sv =====
// Shared types, constants and the mixing row function for the lookup2 byte stream hash.
// Depends on nothing; the gatherer, mixer, result queue and top refer to it by scoped names.
`default_nettype none

package lk2_pkg;

    typedef logic [31:0] word_t;

    localparam word_t GOLDEN_WORD = 32'h9e3779b9;

    localparam logic [3:0] LAST_POS = 4'd11;

    localparam int MIX_ROWS = 9;
    localparam int FIN_WAIT = MIX_ROWS + 2;

    localparam logic [4:0] MIX_SHIFT [MIX_ROWS] = '{
        5'd13, 5'd8, 5'd13, 5'd12, 5'd16, 5'd5, 5'd3, 5'd10, 5'd15
    };
    localparam logic [MIX_ROWS-1:0] MIX_LEFT = 9'b010010010;

    localparam int RES_DEPTH = 32;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic  valid;
        word_t part_a;
        word_t part_b;
        word_t part_c;
    } block_job_t;

    typedef struct packed {
        logic  valid;
        word_t tail_a;
        word_t tail_b;
        word_t tail_c;
    } finish_job_t;

    typedef struct packed {
        logic  valid;
        logic  finish;
        word_t a;
        word_t b;
        word_t c;
    } mix_job_t;

    function automatic word_t mix_row(
        input word_t      x,
        input word_t      y,
        input word_t      z,
        input logic [4:0] sh,
        input logic       left
    );
        word_t d;
        d = x - y - z;
        return left ? (d ^ (z << sh)) : (d ^ (z >> sh));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lk2_in_if.sv =====
// Input channel of the lookup2 byte stream hash: one message byte per transaction.
// Stands alone; carries valid, ready and the byte payload.
`default_nettype none

interface lk2_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    logic       empty_msg;

    modport source (output valid, output data_byte, output last, output empty_msg,
                    input ready);
    modport sink (input valid, input data_byte, input last, input empty_msg,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lk2_out_if.sv =====
// Output channel of the lookup2 byte stream hash: one hash value per transaction.
// Stands alone; carries valid, ready and the hash payload.
`default_nettype none

interface lk2_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lk2_gather.sv =====
// Byte gatherer: packs bytes into three little-endian words, issues a block job per
// twelve bytes and a delayed finish job per message. Depends on lk2_pkg.
`default_nettype none

module lk2_gather (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          data_byte,
    input  wire logic                last,
    input  wire logic                empty_msg,
    output lk2_pkg::block_job_t      blk,
    output lk2_pkg::finish_job_t     fin
);

    lk2_pkg::word_t       part_a_reg, part_a_next;
    lk2_pkg::word_t       part_b_reg, part_b_next;
    lk2_pkg::word_t       part_c_reg, part_c_next;
    lk2_pkg::word_t       byte_total_reg, byte_total_next;
    logic [3:0]           block_pos_reg, block_pos_next;
    lk2_pkg::block_job_t  blk_reg, blk_next;
    logic                 fin0_valid_reg, fin0_valid_next;
    lk2_pkg::word_t       fin0_a_reg, fin0_b_reg, fin0_c_reg, fin0_total_reg;
    lk2_pkg::finish_job_t fin_line_reg [1:lk2_pkg::FIN_WAIT];
    lk2_pkg::word_t       shifted;

    always_comb
    begin
        shifted         = lk2_pkg::word_t'(data_byte) << {block_pos_reg[1:0], 3'b000};
        part_a_next     = part_a_reg;
        part_b_next     = part_b_reg;
        part_c_next     = part_c_reg;
        byte_total_next = byte_total_reg;
        block_pos_next  = block_pos_reg;
        blk_next        = '0;
        if (accept && !empty_msg)
        begin
            case (block_pos_reg[3:2])
                2'd0:    part_a_next = part_a_reg | shifted;
                2'd1:    part_b_next = part_b_reg | shifted;
                default: part_c_next = part_c_reg | shifted;
            endcase
            byte_total_next = byte_total_reg + 32'd1;
            if (block_pos_reg == lk2_pkg::LAST_POS)
            begin
                blk_next.valid  = 1'b1;
                blk_next.part_a = part_a_next;
                blk_next.part_b = part_b_next;
                blk_next.part_c = part_c_next;
                part_a_next     = '0;
                part_b_next     = '0;
                part_c_next     = '0;
                block_pos_next  = '0;
            end
            else
            begin
                block_pos_next = block_pos_reg + 4'd1;
            end
        end
        fin0_valid_next = accept && last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_a_reg     <= '0;
            part_b_reg     <= '0;
            part_c_reg     <= '0;
            byte_total_reg <= '0;
            block_pos_reg  <= '0;
            blk_reg        <= '0;
            fin0_valid_reg <= 1'b0;
        end
        else
        begin
            blk_reg        <= blk_next;
            fin0_valid_reg <= fin0_valid_next;
            if (fin0_valid_next)
            begin
                part_a_reg     <= '0;
                part_b_reg     <= '0;
                part_c_reg     <= '0;
                byte_total_reg <= '0;
                block_pos_reg  <= '0;
            end
            else
            begin
                part_a_reg     <= part_a_next;
                part_b_reg     <= part_b_next;
                part_c_reg     <= part_c_next;
                byte_total_reg <= byte_total_next;
                block_pos_reg  <= block_pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fin0_a_reg     <= part_a_next;
        fin0_b_reg     <= part_b_next;
        fin0_c_reg     <= part_c_next;
        fin0_total_reg <= byte_total_next;
    end

    // The finish job waits until any block mix of the same message has been written back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= lk2_pkg::FIN_WAIT; k++)
            begin
                fin_line_reg[k] <= '0;
            end
        end
        else
        begin
            fin_line_reg[1].valid  <= fin0_valid_reg;
            fin_line_reg[1].tail_a <= fin0_a_reg;
            fin_line_reg[1].tail_b <= fin0_b_reg;
            fin_line_reg[1].tail_c <= fin0_total_reg + {fin0_c_reg[23:0], 8'h00};
            for (int k = 2; k <= lk2_pkg::FIN_WAIT; k++)
            begin
                fin_line_reg[k] <= fin_line_reg[k-1];
            end
        end
    end

    assign blk = blk_reg;
    assign fin = fin_line_reg[lk2_pkg::FIN_WAIT];

endmodule

`default_nettype wire

// ===== rtl/core/lk2_mixer.sv =====
// Nine-row pipelined lookup2 mixer; each stage updates one of the three words.
// Depends on lk2_pkg for the job type, the shift table and the row function.
`default_nettype none

module lk2_mixer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lk2_pkg::mix_job_t job_in,
    output lk2_pkg::mix_job_t      job_out
);

    lk2_pkg::mix_job_t st_reg [0:lk2_pkg::MIX_ROWS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg[0] <= '0;
        end
        else
        begin
            st_reg[0] <= job_in;
        end
    end

    for (genvar r = 0; r < lk2_pkg::MIX_ROWS; r++)
    begin : g_row
        lk2_pkg::mix_job_t row_next;

        always_comb
        begin
            row_next = st_reg[r];
            if (r % 3 == 0)
            begin
                row_next.a = lk2_pkg::mix_row(st_reg[r].a, st_reg[r].b, st_reg[r].c,
                                              lk2_pkg::MIX_SHIFT[r], lk2_pkg::MIX_LEFT[r]);
            end
            else if (r % 3 == 1)
            begin
                row_next.b = lk2_pkg::mix_row(st_reg[r].b, st_reg[r].c, st_reg[r].a,
                                              lk2_pkg::MIX_SHIFT[r], lk2_pkg::MIX_LEFT[r]);
            end
            else
            begin
                row_next.c = lk2_pkg::mix_row(st_reg[r].c, st_reg[r].a, st_reg[r].b,
                                              lk2_pkg::MIX_SHIFT[r], lk2_pkg::MIX_LEFT[r]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_reg[r+1] <= '0;
            end
            else
            begin
                st_reg[r+1] <= row_next;
            end
        end
    end

    assign job_out = st_reg[lk2_pkg::MIX_ROWS];

endmodule

`default_nettype wire

// ===== rtl/core/lk2_result_fifo.sv =====
// Result queue holding finished hash values until the output side takes them.
// Depends on lk2_pkg for its depth and word type.
`default_nettype none

module lk2_result_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire lk2_pkg::word_t wr_data,
    input  wire logic           rd_en,
    output lk2_pkg::word_t      rd_data,
    output logic                not_empty
);

    lk2_pkg::word_t              mem [lk2_pkg::RES_DEPTH];
    logic [lk2_pkg::RES_AW-1:0]  wr_ptr_reg;
    logic [lk2_pkg::RES_AW-1:0]  rd_ptr_reg;
    logic [lk2_pkg::RES_CW-1:0]  count_reg;
    logic                        out_valid_reg;
    lk2_pkg::word_t              out_data_reg;
    logic                        mem_pop;

    function automatic logic [lk2_pkg::RES_AW-1:0] ptr_inc(
        input logic [lk2_pkg::RES_AW-1:0] p
    );
        return (p == lk2_pkg::RES_AW'(lk2_pkg::RES_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // The head entry moves into the output register whenever that register is free.
    assign mem_pop = (count_reg != '0) && (!out_valid_reg || rd_en);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (mem_pop)
        begin
            out_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (mem_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (wr_en && !mem_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (mem_pop && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (mem_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rd_en)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rd_data   = out_data_reg;
    assign not_empty = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lookup2_byte_stream_hash.sv =====
// Lookup2 byte stream hash, one message byte per transaction, one hash per message.
// Throughput is one input transaction per cycle; input ready drops only while 32
// results are outstanding, which is the depth of the result queue.
// From the last byte to a valid hash, the result passes the finish wait line,
// the mixer input register and the nine-row mixing pipeline, then the result queue
// write and its output register.
// Asynchronous active-low reset loads the golden ratio word and clears all counters.
`default_nettype none

module lookup2_byte_stream_hash (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lk2_in_if.sink     msg,
    lk2_out_if.source  res
);

    logic                        in_accept;
    logic                        out_accept;
    logic [lk2_pkg::RES_CW-1:0]  outstanding_reg;
    lk2_pkg::word_t              mix_a_reg, mix_b_reg, mix_c_reg;
    lk2_pkg::block_job_t         blk;
    lk2_pkg::finish_job_t        fin;
    lk2_pkg::mix_job_t           mix_in;
    lk2_pkg::mix_job_t           mix_out;
    lk2_pkg::word_t              fifo_data;
    logic                        fifo_not_empty;

    assign msg.ready  = (outstanding_reg != lk2_pkg::RES_CW'(lk2_pkg::RES_DEPTH));
    assign in_accept  = msg.valid && msg.ready;
    assign out_accept = res.valid && res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else if ((in_accept && msg.last) && !out_accept)
        begin
            outstanding_reg <= outstanding_reg + 1'b1;
        end
        else if (out_accept && !(in_accept && msg.last))
        begin
            outstanding_reg <= outstanding_reg - 1'b1;
        end
    end

    lk2_gather u_gather (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (msg.data_byte),
        .last      (msg.last),
        .empty_msg (msg.empty_msg),
        .blk       (blk),
        .fin       (fin)
    );

    always_comb
    begin
        mix_in.valid  = blk.valid || fin.valid;
        mix_in.finish = fin.valid;
        if (blk.valid)
        begin
            mix_in.a = mix_a_reg + blk.part_a;
            mix_in.b = mix_b_reg + blk.part_b;
            mix_in.c = mix_c_reg + blk.part_c;
        end
        else
        begin
            mix_in.a = mix_a_reg + fin.tail_a;
            mix_in.b = mix_b_reg + fin.tail_b;
            mix_in.c = mix_c_reg + fin.tail_c;
        end
    end

    lk2_mixer u_mixer (
        .clk     (clk),
        .rst_n   (rst_n),
        .job_in  (mix_in),
        .job_out (mix_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_a_reg <= lk2_pkg::GOLDEN_WORD;
            mix_b_reg <= lk2_pkg::GOLDEN_WORD;
            mix_c_reg <= '0;
        end
        else if (mix_out.valid && !mix_out.finish)
        begin
            mix_a_reg <= mix_out.a;
            mix_b_reg <= mix_out.b;
            mix_c_reg <= mix_out.c;
        end
        else if (fin.valid)
        begin
            mix_a_reg <= lk2_pkg::GOLDEN_WORD;
            mix_b_reg <= lk2_pkg::GOLDEN_WORD;
            mix_c_reg <= '0;
        end
    end

    lk2_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (mix_out.valid && mix_out.finish),
        .wr_data   (mix_out.c),
        .rd_en     (out_accept),
        .rd_data   (fifo_data),
        .not_empty (fifo_not_empty)
    );

    assign res.valid      = fifo_not_empty;
    assign res.hash_value = fifo_data;

`ifndef NO_ASSERTIONS
    a_no_job_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(blk.valid && fin.valid))
        else $error("block and finish jobs entered the mixer together");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= lk2_pkg::RES_CW'(lk2_pkg::RES_DEPTH))
        else $error("outstanding result count exceeds queue depth");

    a_result_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (outstanding_reg != '0))
        else $error("result offered with no outstanding message");

    a_finish_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (mix_out.valid && mix_out.finish) |-> (outstanding_reg != '0))
        else $error("finished hash with no outstanding message");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_lookup2_byte_stream_hash.sv =====
`timescale 1ns / 1ps
// Testbench for the lookup2 byte stream hash: a directed table, then random messages
// with idle cycles, a long output hold-off and drain pauses, each hash checked on arrival.
// Depends on lk2_pkg, lk2_in_if, lk2_out_if and lookup2_byte_stream_hash from the RTL.

module tb_lookup2_byte_stream_hash;

    localparam int DIR_ROWS      = 25;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 4000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       empty_msg;
    } byte_item_t;

    localparam byte_item_t DIRECTED [DIR_ROWS] = '{
        '{8'h7E, 1'b1, 1'b1},
        '{8'hFF, 1'b0, 1'b1},
        '{8'h00, 1'b1, 1'b0},
        '{8'hFF, 1'b1, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{8'hFF, 1'b1, 1'b0},
        '{8'hA5, 1'b0, 1'b0},
        '{8'h3C, 1'b0, 1'b1},
        '{8'h5A, 1'b0, 1'b0},
        '{8'hC3, 1'b1, 1'b1},
        '{8'h01, 1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0},
        '{8'h7F, 1'b0, 1'b0},
        '{8'hFE, 1'b0, 1'b0},
        '{8'h10, 1'b1, 1'b0}
    };

    logic clk;
    logic rst_n;

    lk2_in_if  msg_if ();
    lk2_out_if res_if ();

    lookup2_byte_stream_hash i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .res   (res_if)
    );

    lk2_pkg::word_t acc_a;
    lk2_pkg::word_t acc_b;
    lk2_pkg::word_t acc_c;
    lk2_pkg::word_t acc_count;
    logic [3:0]     acc_pos;
    lk2_pkg::word_t part_a;
    lk2_pkg::word_t part_b;
    lk2_pkg::word_t part_c;

    lk2_pkg::word_t pending_hashes [$];

    int  items_taken;
    int  hashes_checked;
    int  backpressure_cycles;
    int  error_count;
    int  quiet_cycles;
    bit  src_idle_en;
    bit  snk_idle_en;
    bit  hold_req;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void scramble_words(inout lk2_pkg::word_t a, inout lk2_pkg::word_t b,
                                           inout lk2_pkg::word_t c);
        a = (a - b - c) ^ (c >> 13);
        b = (b - c - a) ^ (a << 8);
        c = (c - a - b) ^ (b >> 13);
        a = (a - b - c) ^ (c >> 12);
        b = (b - c - a) ^ (a << 16);
        c = (c - a - b) ^ (b >> 5);
        a = (a - b - c) ^ (c >> 3);
        b = (b - c - a) ^ (a << 10);
        c = (c - a - b) ^ (b >> 15);
    endfunction

    function automatic void clear_hash_state();
        acc_a     = lk2_pkg::GOLDEN_WORD;
        acc_b     = lk2_pkg::GOLDEN_WORD;
        acc_c     = '0;
        acc_count = '0;
        acc_pos   = '0;
        part_a    = '0;
        part_b    = '0;
        part_c    = '0;
    endfunction

    function automatic bit absorb_item(input byte_item_t it, output lk2_pkg::word_t digest);
        lk2_pkg::word_t fa;
        lk2_pkg::word_t fb;
        lk2_pkg::word_t fc;
        lk2_pkg::word_t lane_val;
        digest = '0;
        if (!it.empty_msg)
        begin
            lane_val = {24'd0, it.data_byte} << (8 * acc_pos[1:0]);
            case (acc_pos[3:2])
                2'd0:    part_a = part_a | lane_val;
                2'd1:    part_b = part_b | lane_val;
                default: part_c = part_c | lane_val;
            endcase
            acc_count = acc_count + 1;
            if (acc_pos == lk2_pkg::LAST_POS)
            begin
                acc_a = acc_a + part_a;
                acc_b = acc_b + part_b;
                acc_c = acc_c + part_c;
                scramble_words(acc_a, acc_b, acc_c);
                part_a  = '0;
                part_b  = '0;
                part_c  = '0;
                acc_pos = '0;
            end
            else
            begin
                acc_pos = acc_pos + 4'd1;
            end
        end
        if (!it.last)
            return 1'b0;
        fa = acc_a + part_a;
        fb = acc_b + part_b;
        fc = acc_c + acc_count + {part_c[23:0], 8'h00};
        scramble_words(fa, fb, fc);
        digest = fc;
        clear_hash_state();
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : monitor_proc
        lk2_pkg::word_t want;
        lk2_pkg::word_t produced;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (pending_hashes.size() == 0)
                begin
                    $display("%0t: unexpected hash, expected none actual %h",
                             $time, res_if.hash_value);
                    error_count++;
                end
                else
                begin
                    want = pending_hashes.pop_front();
                    if (want !== res_if.hash_value)
                    begin
                        $display("%0t: hash_value mismatch, expected %h actual %h",
                                 $time, want, res_if.hash_value);
                        error_count++;
                    end
                    hashes_checked++;
                end
            end
            if (msg_if.valid && msg_if.ready)
            begin
                if (absorb_item(byte_item_t'{msg_if.data_byte, msg_if.last, msg_if.empty_msg},
                                produced))
                    pending_hashes.push_back(produced);
            end
            if (msg_if.valid && !msg_if.ready)
                backpressure_cycles++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d hashes outstanding",
                     $time, quiet_cycles, pending_hashes.size());
            $display("[lookup2_byte_stream_hash] ERROR");
            $finish;
        end
    end

    initial
    begin : sink_proc
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            res_if.ready <= !(snk_idle_en && ($urandom_range(99) < 11));
        end
    end

    task automatic push_item(input byte_item_t it);
        while (src_idle_en && ($urandom_range(99) < 11))
        begin
            msg_if.valid <= 1'b0;
            @(posedge clk);
        end
        msg_if.valid     <= 1'b1;
        msg_if.data_byte <= it.data_byte;
        msg_if.last      <= it.last;
        msg_if.empty_msg <= it.empty_msg;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        if (it.last || !it.empty_msg)
            items_taken++;
    endtask

    task automatic send_message(input int nbytes);
        byte_item_t it;
        bit         empty_close;
        empty_close = (nbytes == 0) || ($urandom_range(99) < 15);
        for (int i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(99) < 5)
                push_item('{8'($urandom), 1'b0, 1'b1});
            it = '{8'($urandom), 1'b0, 1'b0};
            it.last = (i == nbytes - 1) && !empty_close;
            push_item(it);
        end
        if (empty_close)
            push_item('{8'($urandom), 1'b1, 1'b1});
    endtask

    task automatic send_random_until(input int item_goal);
        int pick;
        int nbytes;
        while (items_taken < item_goal)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                nbytes = 0;
            else if (pick < 75)
                nbytes = $urandom_range(1, 24);
            else if (pick < 95)
                nbytes = $urandom_range(25, 60);
            else
                nbytes = $urandom_range(61, 120);
            send_message(nbytes);
        end
    endtask

    task automatic drain_results();
        msg_if.valid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        msg_if.valid     <= 1'b0;
        msg_if.data_byte <= '0;
        msg_if.last      <= 1'b0;
        msg_if.empty_msg <= 1'b0;
        items_taken         = 0;
        hashes_checked      = 0;
        backpressure_cycles = 0;
        error_count         = 0;
        quiet_cycles        = 0;
        hold_req            = 1'b0;
        src_idle_en         = 1'b1;
        snk_idle_en         = 1'b1;
        clear_hash_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            push_item(DIRECTED[i]);
        drain_results();

        send_random_until(800);
        drain_results();

        // Hold the output while short messages keep coming, so the result queue fills.
        hold_req = 1'b1;
        for (int i = 0; i < 100; i++)
            send_message($urandom_range(1, 3));
        drain_results();

        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        send_random_until(1300);
        drain_results();

        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        send_random_until(1850);
        drain_results();

        $display("Covered %0d byte transactions and %0d checked hashes, %0d cycles of input stall.",
                 items_taken, hashes_checked, backpressure_cycles);
        if (error_count == 0)
            $display("[lookup2_byte_stream_hash] OK");
        else
            $display("[lookup2_byte_stream_hash] ERROR");
        $finish;
    end

endmodule
